[rtl/wevt_pkg.sv]
// Package with the types, sizes and command codes of the weekly event table.
package wevt_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Seconds in one week.
  localparam logic [19:0] WEEK_SECONDS = 20'd604800;

  // Command codes.
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_ACTIVE = 3'd3;
  localparam logic [2:0] CMD_CHECK  = 3'd4;
  localparam logic [2:0] CMD_NEXT   = 3'd5;
  localparam logic [2:0] CMD_READ   = 3'd6;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NO_CHANGE = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  // One command item.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] event_code;
    logic [5:0] week_day;
    logic [5:0] hour_of_day;
    logic [5:0] minute_of_hour;
    logic [5:0] second_of_minute;
    logic [7:0] entry_index;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  position;
    logic [7:0]  code_out;
    logic [19:0] week_seconds_out;
    logic [5:0]  entry_count;
  } rsp_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [19:0] wtime;
    logic [7:0]  code;
  } ent_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_TIME,
    S_SCAN,
    S_DECIDE,
    S_SHUP,
    S_SHDN,
    S_READ,
    S_RDWAIT
  } state_e;

endpackage

[rtl/wevt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module wevt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/weekly_event_table.sv]
// Top level of the weekly event table: command sequencer, sentinel entry and table memory.
// Steps: the week time is formed from day, hour, minute and second; a scan reads the occupied
// entries in order and stops at the first later entry (for an add or delete, also an equal one);
// a decision follows, and an add or delete that moves entries shifts them before the strobe.
// Throughput: one item at a time; busy drops in the strobe cycle; results cannot be stalled.
// Reset leaves only the sentinel entry at time 0 with code 0; no clearing pass is needed.
module weekly_event_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  wevt_pkg::req_t    req_i,
  output logic              valid_o,
  output wevt_pkg::rsp_t    rsp_o
);

  localparam int IDX_W = wevt_pkg::IDX_W;
  localparam int CNT_W = wevt_pkg::CNT_W;

  wevt_pkg::state_e state_q, state_d;
  wevt_pkg::req_t   in_q;
  logic [19:0]      acc_q, acc_d;
  logic [1:0]       step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       code0_q, code0_d;
  logic [IDX_W-1:0] la_q, la_d;
  logic             la_vld_q, la_vld_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             rv_q, rv_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic [IDX_W-1:0] prev_idx_q, prev_idx_d;
  wevt_pkg::ent_t   prev_ent_q, prev_ent_d;
  logic             hit_q, hit_d;
  logic             hit_eq_q, hit_eq_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  wevt_pkg::ent_t   hit_ent_q, hit_ent_d;
  wevt_pkg::rsp_t   res_q, res_d;
  logic             res_vld_q, res_vld_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  wevt_pkg::ent_t   ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  wevt_pkg::ent_t   ram_rdata;

  logic [5:0]       mul_k;
  logic [5:0]       term;
  logic             t_gt;
  logic             t_eq;
  logic             is_edit;
  logic [IDX_W-1:0] nxt_idx;
  wevt_pkg::ent_t   nxt_ent;
  logic [19:0]      nxt_wait;

  // Day minus one after clamping to the range 1..7.
  function automatic logic [2:0] day_m1(input logic [5:0] d);
    logic [2:0] r;
    r = 3'd0;
    if (d >= 6'd1 && d <= 6'd7) begin
      r = 3'(d - 6'd1);
    end
    return r;
  endfunction

  // Clamp a field to zero above its limit.
  function automatic logic [5:0] clamp(input logic [5:0] v, input logic [5:0] lim);
    logic [5:0] r;
    r = v;
    if (v > lim) begin
      r = 6'd0;
    end
    return r;
  endfunction

  // Assemble one result item.
  function automatic wevt_pkg::rsp_t mk_res(input logic [2:0] st, input logic [IDX_W-1:0] pos,
                                            input logic [7:0] code, input logic [19:0] wsec,
                                            input logic [CNT_W-1:0] cnt);
    wevt_pkg::rsp_t r;
    r.status           = st;
    r.position         = 6'(pos);
    r.code_out         = code;
    r.week_seconds_out = wsec;
    r.entry_count      = 6'(cnt);
    return r;
  endfunction

  assign busy    = (state_q != wevt_pkg::S_IDLE);
  assign valid_o = res_vld_q;
  assign rsp_o   = res_q;

  // Table memory; entry 0 lives in flip-flops and its memory slot is never used.
  wevt_ram #(
    .WIDTH($bits(wevt_pkg::ent_t)),
    .DEPTH(wevt_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared compare unit against the query time.
  assign t_gt = (ram_rdata.wtime > acc_q);
  assign t_eq = (ram_rdata.wtime == acc_q);
  assign is_edit = (in_q.cmd == wevt_pkg::CMD_ADD) || (in_q.cmd == wevt_pkg::CMD_DELETE);

  // Constant multiplier and addend for the week time steps.
  always_comb begin
    case (step_q)
      2'd0: begin
        mul_k = 6'd24;
        term  = clamp(in_q.hour_of_day, 6'd23);
      end
      2'd1: begin
        mul_k = 6'd60;
        term  = clamp(in_q.minute_of_hour, 6'd59);
      end
      default: begin
        mul_k = 6'd60;
        term  = clamp(in_q.second_of_minute, 6'd59);
      end
    endcase
  end

  // Next entry and the seconds to wait until it, wrapping at a week.
  always_comb begin
    if (hit_q) begin
      nxt_idx = hit_idx_q;
      nxt_ent = hit_ent_q;
    end else begin
      nxt_idx       = '0;
      nxt_ent.wtime = 20'd0;
      nxt_ent.code  = code0_q;
    end
    if (nxt_ent.wtime >= acc_q) begin
      nxt_wait = nxt_ent.wtime - acc_q;
    end else begin
      nxt_wait = 20'(21'(nxt_ent.wtime) + 21'(wevt_pkg::WEEK_SECONDS) - 21'(acc_q));
    end
  end

  // Sequencer: next state, memory control and results.
  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    code0_d    = code0_q;
    la_d       = la_q;
    la_vld_d   = la_vld_q;
    ptr_d      = ptr_q;
    rv_d       = rv_q;
    ridx_d     = ridx_q;
    prev_idx_d = prev_idx_q;
    prev_ent_d = prev_ent_q;
    hit_d      = hit_q;
    hit_eq_d   = hit_eq_q;
    hit_idx_d  = hit_idx_q;
    hit_ent_d  = hit_ent_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = ptr_q[IDX_W-1:0];

    unique case (state_q)
      wevt_pkg::S_IDLE: begin
        if (start) begin
          state_d = wevt_pkg::S_TIME;
          step_d  = 2'd0;
          acc_d   = 20'(day_m1(req_i.week_day));
        end
      end

      wevt_pkg::S_TIME: begin
        acc_d  = 20'(acc_q * mul_k) + 20'(term);
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          case (in_q.cmd) inside
            wevt_pkg::CMD_ADD, wevt_pkg::CMD_DELETE, wevt_pkg::CMD_ACTIVE,
            wevt_pkg::CMD_CHECK, wevt_pkg::CMD_NEXT: begin
              state_d          = wevt_pkg::S_SCAN;
              ptr_d            = CNT_W'(1);
              rv_d             = 1'b0;
              hit_d            = 1'b0;
              prev_idx_d       = '0;
              prev_ent_d.wtime = 20'd0;
              prev_ent_d.code  = code0_q;
            end
            wevt_pkg::CMD_READ: begin
              state_d = wevt_pkg::S_READ;
            end
            wevt_pkg::CMD_CLEAR: begin
              cnt_d     = CNT_W'(1);
              code0_d   = 8'd0;
              res_d     = mk_res(wevt_pkg::ST_OK, '0, 8'd0, 20'd0, CNT_W'(1));
              res_vld_d = 1'b1;
              state_d   = wevt_pkg::S_IDLE;
            end
            default: begin
              res_d     = mk_res(wevt_pkg::ST_OK, '0, 8'd0, 20'd0, cnt_q);
              res_vld_d = 1'b1;
              state_d   = wevt_pkg::S_IDLE;
            end
          endcase
        end
      end

      wevt_pkg::S_SCAN: begin
        // Check the entry read last cycle; edits stop at an equal time as well.
        if (rv_q) begin
          if (t_gt || (t_eq && is_edit)) begin
            hit_d     = 1'b1;
            hit_eq_d  = t_eq;
            hit_idx_d = ridx_q;
            hit_ent_d = ram_rdata;
            state_d   = wevt_pkg::S_DECIDE;
          end else begin
            prev_idx_d = ridx_q;
            prev_ent_d = ram_rdata;
          end
        end
        // Issue the next read while entries remain.
        if (ptr_q < cnt_q) begin
          ram_raddr = ptr_q[IDX_W-1:0];
          rv_d      = 1'b1;
          ridx_d    = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            state_d = wevt_pkg::S_DECIDE;
          end
        end
      end

      wevt_pkg::S_DECIDE: begin
        state_d   = wevt_pkg::S_IDLE;
        res_vld_d = 1'b1;
        case (in_q.cmd)
          wevt_pkg::CMD_ADD: begin
            if (acc_q == 20'd0) begin
              // Time zero overwrites the sentinel's code.
              code0_d = in_q.event_code;
              res_d   = mk_res(wevt_pkg::ST_OK, '0, in_q.event_code, acc_q, cnt_q);
            end else if (hit_q && hit_eq_q) begin
              ram_we          = 1'b1;
              ram_waddr       = hit_idx_q;
              ram_wdata.wtime = acc_q;
              ram_wdata.code  = in_q.event_code;
              res_d = mk_res(wevt_pkg::ST_OK, hit_idx_q, in_q.event_code, acc_q, cnt_q);
            end else if (cnt_q == CNT_W'(wevt_pkg::TABLE_DEPTH)) begin
              res_d = mk_res(wevt_pkg::ST_FULL, '0, 8'd0, acc_q, cnt_q);
            end else if (hit_q) begin
              // Insert before a later entry: shift the tail up first.
              state_d   = wevt_pkg::S_SHUP;
              res_vld_d = 1'b0;
              ptr_d     = cnt_q - CNT_W'(1);
              rv_d      = 1'b0;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = cnt_q[IDX_W-1:0];
              ram_wdata.wtime = acc_q;
              ram_wdata.code  = in_q.event_code;
              cnt_d           = cnt_q + CNT_W'(1);
              res_d = mk_res(wevt_pkg::ST_OK, cnt_q[IDX_W-1:0], in_q.event_code, acc_q,
                             cnt_q + CNT_W'(1));
            end
          end
          wevt_pkg::CMD_DELETE: begin
            if (hit_q && hit_eq_q) begin
              state_d   = wevt_pkg::S_SHDN;
              res_vld_d = 1'b0;
              ptr_d     = CNT_W'(hit_idx_q) + CNT_W'(1);
              rv_d      = 1'b0;
            end else begin
              res_d = mk_res(wevt_pkg::ST_NOT_FOUND, '0, 8'd0, acc_q, cnt_q);
            end
          end
          wevt_pkg::CMD_ACTIVE: begin
            res_d = mk_res(wevt_pkg::ST_OK, prev_idx_q, prev_ent_q.code, prev_ent_q.wtime,
                           cnt_q);
          end
          wevt_pkg::CMD_CHECK: begin
            la_d     = prev_idx_q;
            la_vld_d = 1'b1;
            if (la_vld_q && (la_q == prev_idx_q)) begin
              res_d = mk_res(wevt_pkg::ST_NO_CHANGE, prev_idx_q, prev_ent_q.code,
                             prev_ent_q.wtime, cnt_q);
            end else begin
              res_d = mk_res(wevt_pkg::ST_OK, prev_idx_q, prev_ent_q.code,
                             prev_ent_q.wtime, cnt_q);
            end
          end
          default: begin
            res_d = mk_res(wevt_pkg::ST_OK, nxt_idx, nxt_ent.code, nxt_wait, cnt_q);
          end
        endcase
      end

      wevt_pkg::S_SHUP: begin
        // Move the entry read last cycle one place up.
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = ridx_q + IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (ptr_q >= CNT_W'(hit_idx_q)) begin
          ram_raddr = ptr_q[IDX_W-1:0];
          rv_d      = 1'b1;
          ridx_d    = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q - CNT_W'(1);
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            ram_we          = 1'b1;
            ram_waddr       = hit_idx_q;
            ram_wdata.wtime = acc_q;
            ram_wdata.code  = in_q.event_code;
            cnt_d           = cnt_q + CNT_W'(1);
            res_d = mk_res(wevt_pkg::ST_OK, hit_idx_q, in_q.event_code, acc_q,
                           cnt_q + CNT_W'(1));
            res_vld_d = 1'b1;
            state_d   = wevt_pkg::S_IDLE;
          end
        end
      end

      wevt_pkg::S_SHDN: begin
        // Move the entry read last cycle one place down.
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = ridx_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (ptr_q < cnt_q) begin
          ram_raddr = ptr_q[IDX_W-1:0];
          rv_d      = 1'b1;
          ridx_d    = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          rv_d = 1'b0;
          if (!rv_q) begin
            cnt_d = cnt_q - CNT_W'(1);
            res_d = mk_res(wevt_pkg::ST_OK, hit_idx_q, hit_ent_q.code, acc_q,
                           cnt_q - CNT_W'(1));
            res_vld_d = 1'b1;
            state_d   = wevt_pkg::S_IDLE;
          end
        end
      end

      wevt_pkg::S_READ: begin
        ram_raddr = in_q.entry_index[IDX_W-1:0];
        if (32'(in_q.entry_index) >= 32'(cnt_q)) begin
          res_d     = mk_res(wevt_pkg::ST_BAD_INDEX, '0, 8'd0, 20'd0, cnt_q);
          res_vld_d = 1'b1;
          state_d   = wevt_pkg::S_IDLE;
        end else if (in_q.entry_index == 8'd0) begin
          res_d     = mk_res(wevt_pkg::ST_OK, '0, code0_q, 20'd0, cnt_q);
          res_vld_d = 1'b1;
          state_d   = wevt_pkg::S_IDLE;
        end else begin
          state_d = wevt_pkg::S_RDWAIT;
        end
      end

      wevt_pkg::S_RDWAIT: begin
        res_d = mk_res(wevt_pkg::ST_OK, in_q.entry_index[IDX_W-1:0], ram_rdata.code,
                       ram_rdata.wtime, cnt_q);
        res_vld_d = 1'b1;
        state_d   = wevt_pkg::S_IDLE;
      end

      default: begin
        state_d = wevt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wevt_pkg::S_IDLE;
      step_q    <= 2'd0;
      cnt_q     <= CNT_W'(1);
      code0_q   <= 8'd0;
      la_q      <= '0;
      la_vld_q  <= 1'b0;
      ptr_q     <= '0;
      rv_q      <= 1'b0;
      hit_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      code0_q   <= code0_d;
      la_q      <= la_d;
      la_vld_q  <= la_vld_d;
      ptr_q     <= ptr_d;
      rv_q      <= rv_d;
      hit_q     <= hit_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q <= req_i;
    end
    acc_q      <= acc_d;
    ridx_q     <= ridx_d;
    prev_idx_q <= prev_idx_d;
    prev_ent_q <= prev_ent_d;
    hit_eq_q   <= hit_eq_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    res_q      <= res_d;
  end

  // The occupied count always includes the sentinel and never exceeds the table.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= CNT_W'(wevt_pkg::TABLE_DEPTH)))
    else $error("entry count out of range");

  // The sentinel slot of the memory is never written.
  a_no_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr != '0))
    else $error("write to sentinel slot");

  // The count changes only together with a result.
  a_cnt_with_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> res_vld_q)
    else $error("count changed without a result");

  // A result follows a busy cycle.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(state_q != wevt_pkg::S_IDLE))
    else $error("result without work");

  // An accepted item makes the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but not busy");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the weekly event table: directed and random command items.
`timescale 1ns / 1ps

module tb_top;
  import wevt_pkg::*;

  // The command code that the block must ignore.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // Keeps a copy of the event table and the responses it must produce.
  class event_table_model;
    logic [19:0] slot_time [TABLE_DEPTH];
    logic [7:0]  slot_code [TABLE_DEPTH];
    int          occupied;
    int          last_active;
    bit          last_active_ok;
    rsp_t        expected_rsp [$];
    int          mismatches;

    function new();
      restore_table();
      last_active    = 0;
      last_active_ok = 1'b0;
      mismatches     = 0;
    endfunction

    // Only the sentinel entry at time 0 with code 0 remains.
    function void restore_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_time[i] = '0;
        slot_code[i] = '0;
      end
      occupied = 1;
    endfunction

    // Second of the week after clamping each field to its legal range.
    function int week_second(req_t r);
      int d, h, m, s;
      d = int'(r.week_day);
      h = int'(r.hour_of_day);
      m = int'(r.minute_of_hour);
      s = int'(r.second_of_minute);
      if (d < 1 || d > 7) d = 1;
      if (h > 23) h = 0;
      if (m > 59) m = 0;
      if (s > 59) s = 0;
      return s + 60 * (m + 60 * (h + 24 * (d - 1)));
    endfunction

    // Last occupied entry whose time is at or before the query.
    function int active_slot(int s);
      int a;
      a = 0;
      for (int i = 0; i < occupied; i++) begin
        if (int'(slot_time[i]) <= s) a = i;
      end
      return a;
    endfunction

    // Applies one command to the table and returns the response it causes.
    function rsp_t predict_response(req_t r);
      rsp_t rsp;
      int   s, hit, ins, pos, wait_s;
      rsp = '0;
      s   = week_second(r);
      hit = -1;
      case (r.cmd) inside
        CMD_CLEAR: begin
          restore_table();
        end
        CMD_ADD: begin
          rsp.week_seconds_out = 20'(s);
          ins = occupied;
          for (int i = occupied - 1; i >= 0; i--) begin
            if (int'(slot_time[i]) == s) hit = i;
            if (int'(slot_time[i]) > s) ins = i;
          end
          if (hit < 0 && occupied >= TABLE_DEPTH) begin
            rsp.status = ST_FULL;
          end else begin
            if (hit < 0) begin
              // Open a gap at the insert point by moving later entries up.
              for (int k = occupied; k > ins; k--) begin
                slot_time[k] = slot_time[k - 1];
                slot_code[k] = slot_code[k - 1];
              end
              occupied++;
              hit = ins;
            end
            slot_time[hit] = 20'(s);
            slot_code[hit] = r.event_code;
            rsp.position   = 6'(hit);
            rsp.code_out   = r.event_code;
          end
        end
        CMD_DELETE: begin
          rsp.week_seconds_out = 20'(s);
          rsp.status           = ST_NOT_FOUND;
          // The sentinel can never match.
          for (int i = occupied - 1; i >= 1; i--) begin
            if (int'(slot_time[i]) == s) hit = i;
          end
          if (hit > 0) begin
            rsp.status   = ST_OK;
            rsp.position = 6'(hit);
            rsp.code_out = slot_code[hit];
            for (int k = hit; k + 1 < occupied; k++) begin
              slot_time[k] = slot_time[k + 1];
              slot_code[k] = slot_code[k + 1];
            end
            occupied--;
            slot_time[occupied] = '0;
            slot_code[occupied] = '0;
          end
        end
        CMD_ACTIVE, CMD_CHECK: begin
          pos                  = active_slot(s);
          rsp.position         = 6'(pos);
          rsp.code_out         = slot_code[pos];
          rsp.week_seconds_out = slot_time[pos];
          if (r.cmd == CMD_CHECK) begin
            if (last_active_ok && last_active == pos) begin
              rsp.status = ST_NO_CHANGE;
            end else begin
              last_active    = pos;
              last_active_ok = 1'b1;
            end
          end
        end
        CMD_NEXT: begin
          pos = active_slot(s) + 1;
          if (pos >= occupied) pos = 0;
          wait_s = int'(slot_time[pos]) - s;
          // A next event earlier in the week is reached after the wrap.
          if (wait_s < 0) wait_s = wait_s + int'(WEEK_SECONDS);
          rsp.position         = 6'(pos);
          rsp.code_out         = slot_code[pos];
          rsp.week_seconds_out = 20'(wait_s);
        end
        CMD_READ: begin
          if (int'(r.entry_index) < occupied) begin
            rsp.position         = 6'(r.entry_index);
            rsp.code_out         = slot_code[r.entry_index];
            rsp.week_seconds_out = slot_time[r.entry_index];
          end else begin
            rsp.status = ST_BAD_INDEX;
          end
        end
        default: begin
        end
      endcase
      rsp.entry_count = 6'(occupied);
      return rsp;
    endfunction

    // Called for every command item the block accepts.
    function void note_command(req_t r);
      expected_rsp.push_back(predict_response(r));
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
        mismatches++;
      end
    endfunction

    // Called for every response strobe; matches it against the oldest prediction.
    function void check_response(rsp_t act);
      rsp_t exp;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with no command waiting: actual %p", $time, act);
        mismatches++;
      end else begin
        exp = expected_rsp.pop_front();
        compare_field("status", 32'(exp.status), 32'(act.status));
        compare_field("position", 32'(exp.position), 32'(act.position));
        compare_field("code_out", 32'(exp.code_out), 32'(act.code_out));
        compare_field("week_seconds_out", 32'(exp.week_seconds_out),
                      32'(act.week_seconds_out));
        compare_field("entry_count", 32'(exp.entry_count), 32'(act.entry_count));
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic valid_o;
  req_t req    = '0;
  rsp_t rsp_o;

  event_table_model model = new();

  weekly_event_table u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Every strobed response is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) model.check_response(rsp_o);
  end

  // Offers one item from a falling edge and returns at the falling edge after it is taken.
  task automatic send_item(req_t r);
    start <= 1'b1;
    req   <= r;
    do begin
      @(posedge clk_i);
    end while (busy);
    model.note_command(r);
    @(negedge clk_i);
  endtask

  // Leaves start low for the given number of cycles.
  task automatic idle_for(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  function automatic req_t make_cmd(logic [2:0] c, logic [7:0] code, logic [5:0] d,
                                    logic [5:0] h, logic [5:0] m, logic [5:0] sec,
                                    logic [7:0] idx);
    req_t r;
    r.cmd              = c;
    r.event_code       = code;
    r.week_day         = d;
    r.hour_of_day      = h;
    r.minute_of_hour   = m;
    r.second_of_minute = sec;
    r.entry_index      = idx;
    return r;
  endfunction

  // A legal day, hour, minute and second, with random code and index.
  function automatic req_t fresh_time(logic [2:0] c);
    return make_cmd(c, 8'($urandom_range(0, 255)), 6'($urandom_range(1, 7)),
                    6'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                    6'($urandom_range(0, 59)), 8'($urandom_range(0, 35)));
  endfunction

  // Main stimulus.
  initial begin
    req_t r;
    req_t time_pool [48];
    int   roll;
    int   burst_left;
    int   drain;

    foreach (time_pool[i]) time_pool[i] = fresh_time(CMD_ADD);

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: the table right after reset, clamping, the sentinel and the boundaries.
    send_item(make_cmd(CMD_READ,   8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd0));
    send_item(make_cmd(CMD_READ,   8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd1));
    send_item(make_cmd(CMD_READ,   8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd255));
    send_item(make_cmd(CMD_ACTIVE, 8'h00, 6'd7,  6'd23, 6'd59, 6'd59, 8'd0));
    send_item(make_cmd(CMD_CHECK,  8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd0));
    send_item(make_cmd(CMD_CHECK,  8'h00, 6'd7,  6'd23, 6'd59, 6'd59, 8'd0));
    send_item(make_cmd(CMD_NEXT,   8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd0));
    send_item(make_cmd(CMD_NEXT,   8'h00, 6'd7,  6'd23, 6'd59, 6'd59, 8'd0));
    send_item(make_cmd(CMD_ADD,    8'hFF, 6'd7,  6'd23, 6'd59, 6'd59, 8'hFF));
    // Out-of-range fields all clamp, so this overwrites the sentinel's code.
    send_item(make_cmd(CMD_ADD,    8'h5A, 6'd0,  6'd63, 6'd60, 6'd63, 8'd0));
    send_item(make_cmd(CMD_ADD,    8'hA5, 6'd63, 6'd12, 6'd30, 6'd15, 8'd0));
    send_item(make_cmd(CMD_ADD,    8'h3C, 6'd8,  6'd24, 6'd63, 6'd60, 8'd0));
    send_item(make_cmd(CMD_ADD,    8'h81, 6'd3,  6'd5,  6'd0,  6'd0,  8'd0));
    send_item(make_cmd(CMD_DELETE, 8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd0));
    send_item(make_cmd(CMD_DELETE, 8'h00, 6'd2,  6'd2,  6'd2,  6'd2,  8'd0));
    send_item(make_cmd(CMD_ACTIVE, 8'h00, 6'd3,  6'd5,  6'd0,  6'd0,  8'd0));
    send_item(make_cmd(CMD_NEXT,   8'h00, 6'd3,  6'd4,  6'd59, 6'd59, 8'd0));
    send_item(make_cmd(CMD_CHECK,  8'h00, 6'd3,  6'd5,  6'd0,  6'd1,  8'd0));
    send_item(make_cmd(CMD_READ,   8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd2));
    send_item(make_cmd(CMD_READ,   8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd3));
    send_item(make_cmd(CMD_DELETE, 8'h00, 6'd3,  6'd5,  6'd0,  6'd0,  8'd0));
    send_item(make_cmd(CMD_UNUSED, 8'hFF, 6'd63, 6'd63, 6'd63, 6'd63, 8'hFF));
    send_item(make_cmd(CMD_CLEAR,  8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd0));
    send_item(make_cmd(CMD_READ,   8'h00, 6'd1,  6'd0,  6'd0,  6'd0,  8'd1));

    // Random: mostly reused times so that overwrites and deletes hit, with fill bursts.
    burst_left = 0;
    for (int n = 0; n < 400; n++) begin
      if (n % 130 == 60) burst_left = 36;
      if (burst_left > 0) begin
        r = fresh_time(CMD_ADD);
        burst_left--;
      end else begin
        roll = $urandom_range(0, 99);
        r    = time_pool[$urandom_range(0, 47)];
        if (roll < 35)      r.cmd = CMD_ADD;
        else if (roll < 50) r.cmd = CMD_DELETE;
        else if (roll < 60) r.cmd = CMD_ACTIVE;
        else if (roll < 70) r.cmd = CMD_CHECK;
        else if (roll < 80) r.cmd = CMD_NEXT;
        else if (roll < 95) r.cmd = CMD_READ;
        else if (roll < 97) r.cmd = CMD_CLEAR;
        else                r.cmd = CMD_UNUSED;
        r.event_code = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 25) begin
          r.week_day         = 6'($urandom_range(0, 63));
          r.hour_of_day      = 6'($urandom_range(0, 63));
          r.minute_of_hour   = 6'($urandom_range(0, 63));
          r.second_of_minute = 6'($urandom_range(0, 63));
        end
        if ($urandom_range(0, 99) < 80) r.entry_index = 8'($urandom_range(0, 35));
        else                            r.entry_index = 8'($urandom_range(0, 255));
      end
      // Random gaps, except in one long stretch that keeps the block fed.
      if ((n < 150 || n >= 250) && $urandom_range(0, 99) < 24) begin
        idle_for($urandom_range(1, 80));
      end
      send_item(r);
    end
    start <= 1'b0;

    // Let the last responses arrive, then allow for the block's latency.
    drain = 0;
    while (model.expected_rsp.size() != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (80) @(posedge clk_i);

    if (model.expected_rsp.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, model.expected_rsp.size());
      model.mismatches++;
    end
    if (model.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
